[hdl/brsb_pkg.sv]
// Shared constants, types and helper functions of the byte ring stream buffer.
`default_nettype none

package brsb_pkg;

    // Storage geometry.
    localparam int DEPTH     = 1024;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int STEP_W    = $clog2(ADDR_W);

    // Read grant limits.
    localparam int MAX_GRANT = 64;
    localparam int GRANT_W   = $clog2(MAX_GRANT + 1);

    // Item field widths.
    localparam int OP_W      = 2;
    localparam int BYTE_W    = 8;
    localparam int FIELD_W   = 7;
    localparam int STAT_W    = 2;
    localparam int CFG_W     = 11;
    localparam int CMP_W     = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;

    // Stream packing.
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = BYTE_W;
    localparam int M_TUSER_W = STAT_W + 1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 2'd0,
        OP_READ = 2'd1,
        OP_MARK = 2'd2
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_AGAIN   = 2'd1,
        STAT_EOS     = 2'd2,
        STAT_REFUSED = 2'd3
    } t_status;

    typedef struct packed {
        logic                last;
        logic [BYTE_W-1:0]   rd_byte;
        logic                has_data;
        t_status             status;
    } t_result;

    // Ring size in use: zero acts as one, anything above the storage depth as the depth.
    function automatic logic [CNT_W-1:0] clamp_size(input logic [CFG_W-1:0] value);
        logic [CNT_W-1:0] size;
        if (value == '0) begin
            size = CNT_W'(1);
        end else if (int'(value) > DEPTH) begin
            size = CNT_W'(DEPTH);
        end else begin
            size = CNT_W'(value);
        end
        return size;
    endfunction

endpackage

`default_nettype wire

[hdl/brsb_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module brsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // Read data holds while no read is issued.
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hdl/brsb_mod.sv]
// Serial restoring remainder unit: rewraps the read pointer after a ring size change.
`default_nettype none

module brsb_mod (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [brsb_pkg::ADDR_W-1:0] i_dividend,
    input  wire logic [brsb_pkg::CNT_W-1:0]  i_divisor,
    output logic                             o_done,
    output logic      [brsb_pkg::ADDR_W-1:0] o_rem
);

    import brsb_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_cnt,  n_cnt;
    logic [ADDR_W-1:0] r_dvd,  n_dvd;
    logic [CNT_W-1:0]  r_rem,  n_rem;
    logic [CNT_W-1:0]  r_div,  n_div;
    logic [CNT_W-1:0]  shifted;

    // One quotient bit per cycle, most significant first.
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        n_div   = r_div;
        shifted = {r_rem[ADDR_W-1:0], r_dvd[ADDR_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = STEP_W'(ADDR_W - 1);
            n_dvd  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = (shifted >= r_div) ? (shifted - r_div) : shifted;
            n_dvd = {r_dvd[ADDR_W-2:0], 1'b0};
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[ADDR_W-1:0];

endmodule

`default_nettype wire

[hdl/byte_ring_stream_buffer.sv]
// Top level of the byte ring stream buffer: control, pointers and result register.
//
// Channel    | Dir | Handshake                       | Contents
// s_axis     | in  | i_s_axis_tvalid/o_s_axis_tready | operation, data byte, min and max count
// m_axis     | out | o_m_axis_tvalid/i_m_axis_tready | status, has_data, read byte, last
// cfg        | in  | i_cfg_valid/o_cfg_ready         | ring size (buffer_size)
//
// Load, mark and refused or empty reads each give one result.
// A read granting N bytes streams them from the single RAM read port at one byte
// per cycle while the output is not stalled, and the block takes no item meanwhile.
// A size write runs a serial remainder over the pointer, with no item taken meanwhile.
// Reset is synchronous and active low; storage is not cleared and holds nothing until loaded.
// A stalled output holds its result and stops further RAM reads after one pending byte.
`default_nettype none

module byte_ring_stream_buffer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Input items.
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [7:0] data_byte, [14:8] min_count, [21:15] max_count, [23:22] zero.
    input  wire logic [brsb_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // [1:0] operation.
    input  wire logic [brsb_pkg::S_TUSER_W-1:0] i_s_axis_tuser,
    // Result items.
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // [7:0] read_byte.
    output logic      [brsb_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // [1:0] status, [2] has_data.
    output logic      [brsb_pkg::M_TUSER_W-1:0] o_m_axis_tuser,
    output logic                                o_m_axis_tlast,
    // Ring size register.
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [brsb_pkg::CFG_W-1:0]     i_cfg_data
);

    import brsb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_STREAM = 3'b010,
        ST_MOD    = 3'b100
    } t_state;

    t_state             r_state,     n_state;
    logic [CNT_W-1:0]   r_size,      n_size;
    logic [ADDR_W-1:0]  r_rp,        n_rp;
    logic [ADDR_W-1:0]  r_rp_raw,    n_rp_raw;
    logic [CNT_W-1:0]   r_fill,      n_fill;
    logic               r_end,       n_end;
    logic [GRANT_W-1:0] r_remaining, n_remaining;
    logic               r_pend,      n_pend;
    logic               r_pend_last, n_pend_last;
    logic               r_out_valid, n_out_valid;
    t_result            r_out,       n_out;
    logic               r_mod_start, n_mod_start;

    logic               s_accept;
    logic               cfg_accept;
    logic               out_free;
    logic               pend_move;
    logic [BYTE_W-1:0]  in_byte;
    logic [FIELD_W-1:0] in_min;
    logic [FIELD_W-1:0] in_max;
    logic [CMP_W-1:0]   fill_x, min_x, max_x, maxs_x, grant_x;
    logic [GRANT_W-1:0] grant;
    logic [CNT_W-1:0]   tail_sum, tail;
    logic [CNT_W-1:0]   rp_inc;
    logic [ADDR_W-1:0]  rp_next;
    logic               load_refused;
    logic               ram_we, ram_re;
    logic [BYTE_W-1:0]  ram_rdata;
    logic               mod_done;
    logic [ADDR_W-1:0]  mod_rem;

    assign in_byte = i_s_axis_tdata[BYTE_W-1:0];
    assign in_min  = i_s_axis_tdata[BYTE_W+FIELD_W-1:BYTE_W];
    assign in_max  = i_s_axis_tdata[BYTE_W+2*FIELD_W-1:BYTE_W+FIELD_W];

    // Handshakes. A pending size write wins over an item offered in the same cycle.
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_cfg_ready     = (r_state == ST_IDLE);
    assign cfg_accept      = i_cfg_valid && o_cfg_ready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && !i_cfg_valid && out_free;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Read grant: the max count saturates at MAX_GRANT and never exceeds the fill.
    assign fill_x  = CMP_W'(r_fill);
    assign min_x   = CMP_W'(in_min);
    assign max_x   = CMP_W'(in_max);
    assign maxs_x  = (max_x > CMP_W'(MAX_GRANT)) ? CMP_W'(MAX_GRANT) : max_x;
    assign grant_x = (fill_x < maxs_x) ? fill_x : maxs_x;
    assign grant   = grant_x[GRANT_W-1:0];

    // Tail slot. The pointer is kept below the ring size and a load is only taken
    // while the fill is below it, so one conditional subtract wraps the sum.
    assign load_refused = r_end || (r_fill >= r_size);
    assign tail_sum     = CNT_W'(r_rp) + CNT_W'(r_fill[ADDR_W-1:0]);
    assign tail         = (tail_sum >= r_size) ? (tail_sum - r_size) : tail_sum;

    assign rp_inc  = CNT_W'(r_rp) + CNT_W'(1);
    assign rp_next = (rp_inc == r_size) ? '0 : rp_inc[ADDR_W-1:0];

    // The RAM output register is the first of two stages while streaming;
    // its byte moves on whenever the result register is free.
    assign pend_move = r_pend && out_free;

    always_comb begin
        n_state     = r_state;
        n_size      = r_size;
        n_rp        = r_rp;
        n_rp_raw    = r_rp_raw;
        n_fill      = r_fill;
        n_end       = r_end;
        n_remaining = r_remaining;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out       = r_out;
        n_mod_start = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (cfg_accept) begin
                    n_size      = clamp_size(i_cfg_data);
                    n_mod_start = 1'b1;
                    n_state     = ST_MOD;
                end else if (s_accept) begin
                    unique case (t_op'(i_s_axis_tuser))
                        OP_LOAD: begin
                            n_out_valid = 1'b1;
                            n_out       = '{last: 1'b1, rd_byte: '0, has_data: 1'b0,
                                            status: STAT_OK};
                            if (load_refused) begin
                                n_out.status = STAT_REFUSED;
                            end else begin
                                ram_we = 1'b1;
                                n_fill = r_fill + CNT_W'(1);
                            end
                        end
                        OP_MARK: begin
                            n_end       = 1'b1;
                            n_out_valid = 1'b1;
                            n_out       = '{last: 1'b1, rd_byte: '0, has_data: 1'b0,
                                            status: STAT_OK};
                        end
                        OP_READ: begin
                            n_out_valid = 1'b1;
                            n_out       = '{last: 1'b1, rd_byte: '0, has_data: 1'b0,
                                            status: STAT_OK};
                            priority if (r_fill == '0 && r_end) begin
                                n_out.status = STAT_EOS;
                            end else if (fill_x < min_x) begin
                                n_out.status = STAT_AGAIN;
                            end else if (grant != '0) begin
                                // Bytes follow from the RAM; no result for the request itself.
                                n_out_valid = r_out_valid && !i_m_axis_tready;
                                n_out       = r_out;
                                n_remaining = grant;
                                n_fill      = r_fill - CNT_W'(grant);
                                n_state     = ST_STREAM;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_STREAM: begin
                if (pend_move) begin
                    n_out_valid = 1'b1;
                    n_out       = '{last: r_pend_last, rd_byte: ram_rdata, has_data: 1'b1,
                                    status: STAT_OK};
                    n_pend      = 1'b0;
                end
                if (r_remaining != '0 && (!r_pend || pend_move)) begin
                    ram_re      = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_last = (r_remaining == GRANT_W'(1));
                    n_remaining = r_remaining - GRANT_W'(1);
                    n_rp        = rp_next;
                    n_rp_raw    = rp_next;
                end
                if (n_remaining == '0 && !n_pend) begin
                    n_state = ST_IDLE;
                end
            end
            ST_MOD: begin
                // The raw pointer is kept so that a later size change wraps it afresh.
                if (mod_done) begin
                    n_rp    = mod_rem;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_size      <= CNT_W'(DEPTH);
            r_rp        <= '0;
            r_rp_raw    <= '0;
            r_fill      <= '0;
            r_end       <= 1'b0;
            r_remaining <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_mod_start <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_size      <= n_size;
            r_rp        <= n_rp;
            r_rp_raw    <= n_rp_raw;
            r_fill      <= n_fill;
            r_end       <= n_end;
            r_remaining <= n_remaining;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_mod_start <= n_mod_start;
        end
        r_pend_last <= n_pend_last;
        r_out       <= n_out;
    end

    brsb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_storage (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (tail[ADDR_W-1:0]),
        .i_wdata (in_byte),
        .i_re    (ram_re),
        .i_raddr (r_rp),
        .o_rdata (ram_rdata)
    );

    brsb_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_mod_start),
        .i_dividend (r_rp_raw),
        .i_divisor  (r_size),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.rd_byte;
    assign o_m_axis_tuser  = {r_out.has_data, r_out.status};
    assign o_m_axis_tlast  = r_out.last;

`ifndef SYNTH
    // A RAM byte is only in flight while a read grant is being streamed.
    a_pend_in_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == ST_STREAM))
        else $error("read byte pending outside streaming");

    // Loads never write while a grant is being read out.
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_IDLE))
        else $error("storage written while not idle");

    // No RAM read beyond the granted byte count.
    a_read_granted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |-> (r_remaining != '0))
        else $error("storage read with no bytes left in the grant");

    // After a size change the pointer lies inside the new ring.
    a_rp_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOD && mod_done) |=> (CNT_W'(r_rp) < r_size))
        else $error("read pointer outside the ring after a size change");

    // The fill never exceeds the storage depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_fill <= CNT_W'(DEPTH)))
        else $error("fill count beyond storage depth");
`endif

endmodule

`default_nettype wire

[test/byte_ring_stream_buffer_test.sv]
// Self-checking testbench of the byte ring stream buffer, with its own ring predictor.
module byte_ring_stream_buffer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import brsb_pkg::*;

    // The operation code that the block has to ignore without giving a result.
    localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
    localparam int              CYCLE_LIMIT = 2_000_000;
    localparam int              SETTLE      = 16;
    localparam int              REPORT_MAX  = 10;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] i_s_axis_tuser = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic [M_TUSER_W-1:0] o_m_axis_tuser;
    logic                 o_m_axis_tlast;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    byte_ring_stream_buffer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Predicted ring contents and control state, updated as each item is accepted.
    logic [BYTE_W-1:0] ring_mem [DEPTH];
    int                head_ptr = 0;
    int                held_count = 0;
    bit                stream_ended = 1'b0;
    logic [CFG_W-1:0]  ring_size_reg = CFG_W'(DEPTH);

    // Results still owed by the block, oldest first.
    t_result           awaited_results [$];

    int                mismatches = 0;
    int                cycle_count = 0;
    // Idling odds: one chance in idle_odds per item or cycle; zero turns idling off.
    int                idle_odds = 4;
    int                stall_left = 0;
    // Long receiver hold-off, counted down by the receiver process.
    int                hold_off = 0;

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("%0t: %s", $time, msg);
        end
    endfunction

    function automatic void await_result(t_status st, logic hd, logic [BYTE_W-1:0] b,
                                         logic last);
        t_result r;
        r.status   = st;
        r.has_data = hd;
        r.rd_byte  = b;
        r.last     = last;
        awaited_results.push_back(r);
    endfunction

    // Works out the results of one accepted item and moves the ring state on.
    function automatic void predict_results(logic [OP_W-1:0] op, logic [BYTE_W-1:0] value,
                                            logic [FIELD_W-1:0] least,
                                            logic [FIELD_W-1:0] most);
        int size;
        int grant;
        int p;
        if (ring_size_reg == '0) begin
            size = 1;
        end else if (int'(ring_size_reg) > DEPTH) begin
            size = DEPTH;
        end else begin
            size = int'(ring_size_reg);
        end
        if (op == OP_LOAD) begin
            if (stream_ended || held_count >= size) begin
                await_result(STAT_REFUSED, 1'b0, 8'h00, 1'b1);
            end else begin
                ring_mem[(head_ptr + held_count) % size] = value;
                held_count++;
                await_result(STAT_OK, 1'b0, 8'h00, 1'b1);
            end
        end else if (op == OP_MARK) begin
            stream_ended = 1'b1;
            await_result(STAT_OK, 1'b0, 8'h00, 1'b1);
        end else if (op == OP_READ) begin
            // End of stream wins over the minimum test.
            if (held_count == 0 && stream_ended) begin
                await_result(STAT_EOS, 1'b0, 8'h00, 1'b1);
            end else if (held_count < int'(least)) begin
                await_result(STAT_AGAIN, 1'b0, 8'h00, 1'b1);
            end else begin
                grant = (int'(most) > MAX_GRANT) ? MAX_GRANT : int'(most);
                if (held_count < grant) begin
                    grant = held_count;
                end
                if (grant == 0) begin
                    await_result(STAT_OK, 1'b0, 8'h00, 1'b1);
                end else begin
                    p = head_ptr % size;
                    for (int i = 0; i < grant; i++) begin
                        await_result(STAT_OK, 1'b1, ring_mem[p], (i == grant - 1));
                        p = (p + 1 == size) ? 0 : p + 1;
                    end
                    head_ptr   = p;
                    held_count -= grant;
                end
            end
        end
    endfunction

    // Offers one item, with a random gap in front, and predicts it once it is taken.
    // Called and left at a falling edge; tvalid stays high for a following item.
    task automatic send_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] value,
                             logic [FIELD_W-1:0] least, logic [FIELD_W-1:0] most);
        int gap;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            gap = $urandom_range(1, 11);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, most, least, value};
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_results(op, value, least, most);
        @(negedge i_clk);
    endtask

    // Stops offering items until every owed result has come, then lets the block settle.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (awaited_results.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Reads the ring dry so that a new size never exposes unwritten entries.
    task automatic empty_ring();
        while (held_count > 0) begin
            send_item(OP_READ, 8'($urandom), 7'd0, 7'd64);
        end
    endtask

    task automatic write_ring_size(logic [CFG_W-1:0] value);
        empty_ring();
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        ring_size_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly small counts, some across the whole legal range, some above it.
    function automatic logic [FIELD_W-1:0] pick_count(int near);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return FIELD_W'($urandom_range(0, near));
        end else if (r < 90) begin
            return FIELD_W'($urandom_range(0, MAX_GRANT));
        end
        return FIELD_W'($urandom_range(MAX_GRANT + 1, 127));
    endfunction

    task automatic random_items(int count);
        int sent;
        int r;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                send_item(OP_UNUSED, 8'($urandom), 7'($urandom), 7'($urandom));
            end else if (r < 52) begin
                send_item(OP_LOAD, 8'($urandom), 7'($urandom), 7'($urandom));
                sent++;
            end else begin
                send_item(OP_READ, 8'($urandom), pick_count(8), pick_count(16));
                sent++;
            end
        end
    endtask

    // Every read outcome but end of stream, and field extremes, at the reset size, before any mark.
    task automatic test_directed_reads();
        send_item(OP_READ, 8'h00, 7'd0, 7'd5);      // empty, min zero: empty grant
        send_item(OP_READ, 8'hFF, 7'd1, 7'd5);      // empty, min one: again
        send_item(OP_LOAD, 8'h00, 7'd0, 7'd0);
        send_item(OP_LOAD, 8'hFF, 7'h7F, 7'h7F);
        send_item(OP_LOAD, 8'hA5, 7'd0, 7'd0);
        send_item(OP_LOAD, 8'h5A, 7'd0, 7'd0);
        send_item(OP_READ, 8'h00, 7'd5, 7'd10);     // too few held
        send_item(OP_READ, 8'h00, 7'd2, 7'd0);      // max zero grants nothing
        send_item(OP_READ, 8'h00, 7'd3, 7'd2);      // min above max: two bytes
        send_item(OP_UNUSED, 8'hFF, 7'h7F, 7'h7F);  // ignored
        send_item(OP_READ, 8'h00, 7'd0, 7'h7F);     // max saturates, two bytes
        repeat (6) send_item(OP_LOAD, 8'($urandom), 7'd0, 7'd0);
        send_item(OP_READ, 8'h00, 7'd64, 7'd64);    // again
        send_item(OP_READ, 8'h00, 7'h7F, 7'd1);     // min beyond the limit: again
        send_item(OP_READ, 8'h00, 7'd6, 7'd64);     // all six
        wait_drained();
    endtask

    // Smallest and largest ring sizes, out-of-range values, wrap-around and refusal.
    task automatic test_ring_sizes();
        write_ring_size(11'd16);
        repeat (20) send_item(OP_LOAD, 8'($urandom), 7'd0, 7'd0);  // last four refused
        send_item(OP_READ, 8'h00, 7'd16, 7'd64);
        repeat (10) send_item(OP_LOAD, 8'($urandom), 7'd0, 7'd0);
        send_item(OP_READ, 8'h00, 7'd0, 7'd7);
        repeat (14) send_item(OP_LOAD, 8'($urandom), 7'd0, 7'd0);  // wraps, one refused
        send_item(OP_READ, 8'h00, 7'd16, 7'd64);
        send_item(OP_READ, 8'h00, 7'd0, 7'd64);
        // Zero behaves as a one-byte ring.
        write_ring_size(11'd0);
        repeat (2) send_item(OP_LOAD, 8'($urandom), 7'd0, 7'd0);
        send_item(OP_READ, 8'h00, 7'd0, 7'd1);
        write_ring_size(11'd1);
        repeat (3) send_item(OP_LOAD, 8'($urandom), 7'd0, 7'd0);
        send_item(OP_READ, 8'h00, 7'd1, 7'd64);
        // All ones behaves as the full depth.
        write_ring_size(11'h7FF);
        repeat (5) send_item(OP_LOAD, 8'($urandom), 7'd0, 7'd0);
        send_item(OP_READ, 8'h00, 7'd2, 7'd3);
        write_ring_size(CFG_W'(DEPTH));
        repeat (4) send_item(OP_LOAD, 8'($urandom), 7'd0, 7'd0);
    endtask

    // The receiver holds off long enough for the result register to fill and hold back items.
    task automatic test_stalled_output();
        write_ring_size(CFG_W'(DEPTH));
        @(posedge i_clk);
        hold_off = 300;
        @(negedge i_clk);
        repeat (40) send_item(OP_LOAD, 8'($urandom), 7'd0, 7'd0);
        send_item(OP_READ, 8'h00, 7'd0, 7'd64);
        repeat (8) send_item(OP_LOAD, 8'($urandom), 7'd0, 7'd0);
        // The sender now pauses until the backlog is gone.
        wait_drained();
        send_item(OP_READ, 8'h00, 7'd8, 7'd8);
    endtask

    task automatic test_random_traffic();
        write_ring_size(CFG_W'($urandom_range(16, 48)));
        idle_odds = 3;
        random_items(30);
        write_ring_size(CFG_W'(DEPTH));
        idle_odds = 6;
        random_items(25);
        // The last stretch runs without idling on either side.
        write_ring_size(CFG_W'($urandom_range(17, DEPTH - 1)));
        idle_odds = 0;
        random_items(30);
    endtask

    // Marking is one-way, so it comes last: draining, end of stream and refused loads.
    task automatic test_end_of_stream();
        empty_ring();
        repeat (5) send_item(OP_LOAD, 8'($urandom), 7'd0, 7'd0);
        send_item(OP_MARK, 8'h00, 7'd0, 7'd0);
        send_item(OP_LOAD, 8'hFF, 7'd0, 7'd0);      // refused after the mark
        send_item(OP_READ, 8'h00, 7'd10, 7'd64);    // still held, too few: again
        send_item(OP_READ, 8'h00, 7'd0, 7'd3);
        send_item(OP_READ, 8'h00, 7'h7F, 7'h7F);
        send_item(OP_READ, 8'h00, 7'd0, 7'd64);     // the last two bytes
        send_item(OP_READ, 8'h00, 7'd5, 7'd9);      // end of stream before the min test
        send_item(OP_READ, 8'h00, 7'd0, 7'd0);
        send_item(OP_UNUSED, 8'h00, 7'd0, 7'd0);
        send_item(OP_MARK, 8'hFF, 7'h7F, 7'h7F);
        random_items(20);
    endtask

    // Receiver: random stall bursts, plus the long hold-off when one is armed.
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_off--;
        end else if (stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left--;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            i_m_axis_tready <= 1'b0;
            stall_left = $urandom_range(0, 10);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Each accepted result is compared with the oldest one owed.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (awaited_results.size() == 0) begin
                note_mismatch($sformatf("unexpected result status %0d byte %02h",
                                        o_m_axis_tuser[1:0], o_m_axis_tdata));
            end else begin
                want = awaited_results.pop_front();
                if (o_m_axis_tuser[1:0] != want.status || o_m_axis_tuser[2] != want.has_data
                        || o_m_axis_tdata != want.rd_byte || o_m_axis_tlast != want.last) begin
                    note_mismatch($sformatf(
                        "status/has_data/byte/last expected %0d/%0d/%02h/%0d got %0d/%0d/%02h/%0d",
                        want.status, want.has_data, want.rd_byte, want.last,
                        o_m_axis_tuser[1:0], o_m_axis_tuser[2], o_m_axis_tdata,
                        o_m_axis_tlast));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_reads();
        test_ring_sizes();
        test_stalled_output();
        test_random_traffic();
        test_end_of_stream();
        wait_drained();
        repeat (80) @(negedge i_clk);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/brsb_pkg.sv
hdl/brsb_ram.sv
hdl/brsb_mod.sv
hdl/byte_ring_stream_buffer.sv
test/byte_ring_stream_buffer_test.sv
